@@ rtl/ibs_pkg.sv @@
`default_nettype none
package ibs_pkg;

  localparam int unsigned NumCells = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CntW     = $clog2(NumCells + 1);

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [CntW-1:0]         cnt_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } ctrl_t;

  typedef enum logic [1:0] {
    StLoad  = 2'b01,
    StDrain = 2'b10
  } state_e;

endpackage
`default_nettype wire

@@ rtl/ibs_cell.sv @@
`default_nettype none
module ibs_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ibs_pkg::ctrl_t ctrl_i,
  input  wire ibs_pkg::data_t x_i,
  input  wire ibs_pkg::data_t prev_value_i,
  input  wire logic          prev_occ_i,
  input  wire logic          prev_gt_i,
  input  wire ibs_pkg::data_t next_value_i,
  input  wire logic          next_occ_i,
  output ibs_pkg::data_t     value_o,
  output logic               occ_o,
  output logic               gt_o
);

  ibs_pkg::data_t value_q, value_d;
  logic           occ_q, occ_d;

  // The new element goes ahead of this entry when the entry is empty or larger.
  // Equal values stay in front, which keeps the order stable.
  assign gt_o = !occ_q || (x_i < value_q);

  always_comb begin
    value_d = value_q;
    occ_d   = occ_q;
    if (ctrl_i.shift) begin
      value_d = next_value_i;
      occ_d   = next_occ_i;
    end else if (ctrl_i.insert && gt_o) begin
      if (prev_gt_i) begin
        value_d = prev_value_i;
        occ_d   = prev_occ_i;
      end else begin
        value_d = x_i;
        occ_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign value_o = value_q;
  assign occ_o   = occ_q;

endmodule
`default_nettype wire

@@ rtl/integer_block_sorter_top.sv @@
`default_nettype none
// Elements load at one per cycle into a chain of 64 compare-and-insert cells; input
// is held off while a block drains. The first sorted result is valid in the cycle
// after the block_end request is taken; results then leave at one per cycle while
// out_ready_i is high, as the chain shifts toward its head. Reset clears the
// occupancy flags, the element count and the overflow flag, and sets state to StLoad.
module integer_block_sorter_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic signed [31:0]    value_i,
  input  wire logic                  block_end_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [31:0]         sorted_value_o,
  output logic                       run_end_o,
  output logic                       overflowed_o
);

  localparam int unsigned N = ibs_pkg::NumCells;

  ibs_pkg::state_e state_q, state_d;
  ibs_pkg::cnt_t   count_q, count_d;
  logic            ovf_q, ovf_d;
  ibs_pkg::ctrl_t  ctrl;

  ibs_pkg::data_t  cell_value [N];
  logic            cell_occ   [N];
  logic            cell_gt    [N];

  logic in_acc, out_acc, full;

  assign in_ready_o  = (state_q == ibs_pkg::StLoad);
  assign out_valid_o = (state_q == ibs_pkg::StDrain);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign full        = (count_q == ibs_pkg::CntW'(N));

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      ibs_cell u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i       (ctrl),
        .x_i          (value_i),
        .prev_value_i ('0),
        .prev_occ_i   (1'b0),
        .prev_gt_i    (1'b0),
        .next_value_i (cell_value[i+1]),
        .next_occ_i   (cell_occ[i+1]),
        .value_o      (cell_value[i]),
        .occ_o        (cell_occ[i]),
        .gt_o         (cell_gt[i])
      );
    end else if (i == N - 1) begin : g_tail
      ibs_cell u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i       (ctrl),
        .x_i          (value_i),
        .prev_value_i (cell_value[i-1]),
        .prev_occ_i   (cell_occ[i-1]),
        .prev_gt_i    (cell_gt[i-1]),
        .next_value_i ('0),
        .next_occ_i   (1'b0),
        .value_o      (cell_value[i]),
        .occ_o        (cell_occ[i]),
        .gt_o         (cell_gt[i])
      );
    end else begin : g_mid
      ibs_cell u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i       (ctrl),
        .x_i          (value_i),
        .prev_value_i (cell_value[i-1]),
        .prev_occ_i   (cell_occ[i-1]),
        .prev_gt_i    (cell_gt[i-1]),
        .next_value_i (cell_value[i+1]),
        .next_occ_i   (cell_occ[i+1]),
        .value_o      (cell_value[i]),
        .occ_o        (cell_occ[i]),
        .gt_o         (cell_gt[i])
      );
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      ibs_pkg::StLoad: begin
        if (in_acc) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + ibs_pkg::CntW'(1);
          end
          if (block_end_i) begin
            state_d = ibs_pkg::StDrain;
          end
        end
      end
      ibs_pkg::StDrain: begin
        if (out_acc) begin
          count_d = count_q - ibs_pkg::CntW'(1);
          if (count_q == ibs_pkg::CntW'(1)) begin
            state_d = ibs_pkg::StLoad;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ibs_pkg::StLoad;
        count_d = '0;
        ovf_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibs_pkg::StLoad;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign sorted_value_o = cell_value[0];
  assign run_end_o      = (count_q == ibs_pkg::CntW'(1));
  assign overflowed_o   = ovf_q;

endmodule
`default_nettype wire
